>>> hdl/char_lcd_nibble_write_sequencer_top_macros.svh
// Assertion macros used by the character LCD sequencer module.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLCD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/clcd_pkg.sv
// Types, constants and helper functions for the character LCD sequencer.
package clcd_pkg;

   // Request opcodes; the remaining code is ignored.
   typedef enum logic [2:0] {
      OP_CMD   = 3'd0,
      OP_DATA  = 3'd1,
      OP_INIT  = 3'd2,
      OP_CLEAR = 3'd3,
      OP_GOTO  = 3'd4,
      OP_DIG4  = 3'd5,
      OP_DIG2  = 3'd6
   } opcode_type;

   localparam logic [2:0] OP_UNUSED = 3'd7;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_PRE,
      ST_EMIT
   } state_type;

   // Display command bytes.
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0D;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CMD_FUNC_SET    = 8'h2C;
   localparam logic [7:0] CMD_HOME        = 8'h02;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
   localparam logic [7:0] ASCII_ZERO      = 8'h30;
   localparam logic [3:0] NIB_FOUR_BIT    = 4'h2;

   // Saturation limits for decimal printing.
   localparam logic [13:0] DIG4_MAX = 14'd9999;
   localparam logic [13:0] DIG2_MAX = 14'd99;

   // Hold limits and the final snapshot positions within a byte and of the power-up wait.
   localparam int unsigned HOLD_MAX = 100;
   localparam logic [6:0]  HOLD_MIN = 7'd1;
   localparam logic [2:0]  SNAP_FINAL = 3'd4;
   localparam logic [1:0]  PRE_FINAL  = 2'd2;

   // Decimal divisor codes.
   localparam logic [1:0] DIV_THOUSAND = 2'd0;
   localparam logic [1:0] DIV_HUNDRED  = 2'd1;
   localparam logic [1:0] DIV_TEN      = 2'd2;

   // One pin snapshot; RW is always low and is not carried.
   typedef struct packed {
      logic       reg_select;
      logic       enable;
      logic [3:0] nibble;
      logic [6:0] hold_units;
      logic       last;
   } snap_type;

   // Request to and result from the shared add/subtract unit.
   typedef struct packed {
      logic        sub;
      logic [13:0] a;
      logic [13:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [13:0] res;
      logic        borrow;
   } alu_rsp_type;

   // Divisor for a decimal digit position.
   function automatic logic [13:0] divisor(input logic [1:0] code);
      logic [13:0] d;
      unique case (code)
         DIV_THOUSAND: d = 14'd1000;
         DIV_HUNDRED:  d = 14'd100;
         default:      d = 14'd10;
      endcase
      return d;
   endfunction

endpackage

>>> hdl/char_lcd_nibble_write_sequencer_top.sv
// Top level of the 4-bit character LCD write sequencer.
// Each request is expanded into pin snapshots (RS, RW, E, four data lines and a hold
// time), one snapshot per cycle through an output register while the receiver keeps
// up; every byte is five snapshots. A command or data request sends one byte, clear two
// and init five after its power-up wait and 4-bit select snapshots. Goto first adds the
// width once per row in the shared adder. Printing first counts each digit but the last
// by repeated subtraction in the shared subtractor, before its 20 or 10 snapshots. The
// sequence stalls while the receiver holds off a full output register. The request side
// is not ready until the final snapshot of a request has been handed to the output
// register.
module char_lcd_nibble_write_sequencer_top #(
   parameter int unsigned POWERUP_UNITS = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // value[13:0], row[15:14], col[22:16]
   input  logic [2:0]  req_tuser,  // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // read_write[0], enable[1], nibble[5:2],
                                   // hold_units[12:6]
   output logic        rsp_tuser,  // reg_select[0]
   output logic        rsp_tlast,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata   // screen_width[6:0]
);

   logic [6:0]         width_ff, width_in;
   logic               out_valid_ff, out_valid_in;
   clcd_pkg::snap_type out_ff, out_in;
   logic               advance;
   logic               snap_valid;
   clcd_pkg::snap_type snap;

   clcd_seq #(
      .POWERUP_UNITS (POWERUP_UNITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_value  (req_tdata[13:0]),
      .req_row    (req_tdata[15:14]),
      .req_col    (req_tdata[22:16]),
      .width      (width_ff),
      .advance    (advance),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   // Screen width register, always writable.
   assign csr_tready = 1'b1;
   assign width_in   = csr_tvalid ? csr_tdata[6:0] : width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 7'd16;
      end else begin
         width_ff <= width_in;
      end
   end

   // Output register loads whenever it is empty or being drained.
   assign advance      = !out_valid_ff || rsp_tready;
   assign out_valid_in = advance ? snap_valid : out_valid_ff;
   assign out_in       = advance ? snap : out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // Result packing; RW is always driven low.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.hold_units, out_ff.nibble, out_ff.enable, 1'b0};
   assign rsp_tuser  = out_ff.reg_select;
   assign rsp_tlast  = out_ff.last;

endmodule

>>> hdl/clcd_alu.sv
// Shared add/subtract unit used for digit extraction and address arithmetic.
module clcd_alu (
   input  clcd_pkg::alu_req_type req,
   output clcd_pkg::alu_rsp_type rsp
);

   logic [14:0] wide;

   // One 14-bit add or subtract; the top bit is the borrow on subtract.
   always_comb begin
      if (req.sub) begin
         wide = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         wide = {1'b0, req.a} + {1'b0, req.b};
      end
      rsp.res    = wide[13:0];
      rsp.borrow = wide[14];
   end

endmodule

>>> hdl/clcd_seq.sv
// Request sequencer: computes bytes with the shared unit and emits pin snapshots.
`include "char_lcd_nibble_write_sequencer_top_macros.svh"

module clcd_seq #(
   parameter int unsigned POWERUP_UNITS = 100
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic [13:0]        req_value,
   input  logic [1:0]         req_row,
   input  logic [6:0]         req_col,
   input  logic [6:0]         width,
   input  logic               advance,
   output logic               snap_valid,
   output clcd_pkg::snap_type snap
);

   localparam int unsigned WaitUnits =
      (POWERUP_UNITS > clcd_pkg::HOLD_MAX) ? clcd_pkg::HOLD_MAX : POWERUP_UNITS;

   clcd_pkg::state_type  state_ff, state_in;
   clcd_pkg::opcode_type op_ff, op_in;
   logic [13:0]          acc_ff, acc_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic [1:0]           div_ff, div_in;
   logic [3:0][3:0]      dig_ff, dig_in;
   logic [1:0]           di_ff, di_in;
   logic [2:0]           byte_ff, byte_in;
   logic [2:0]           snap_ff, snap_in;
   logic [1:0]           pre_ff, pre_in;
   logic [3:0]           bus_ff, bus_in;

   clcd_pkg::alu_req_type alu_req;
   clcd_pkg::alu_rsp_type alu_rsp;

   logic [7:0] cur_byte;
   logic [2:0] last_idx;
   logic       cur_rs;
   logic [3:0] cur_nib;
   logic       last_byte;

   clcd_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // Shared unit operands: add the width for goto, subtract a divisor for digits.
   always_comb begin
      alu_req.sub = (op_ff != clcd_pkg::OP_GOTO);
      alu_req.a   = acc_ff;
      alu_req.b   = (op_ff == clcd_pkg::OP_GOTO) ? {7'd0, width}
                                                 : clcd_pkg::divisor(div_ff);
   end

   // Byte under transmission, its RS level and the index of the final byte.
   always_comb begin
      cur_byte = '0;
      last_idx = '0;
      cur_rs   = 1'b0;
      unique case (op_ff)
         clcd_pkg::OP_CMD: begin
            cur_byte = acc_ff[7:0];
         end
         clcd_pkg::OP_DATA: begin
            cur_byte = acc_ff[7:0];
            cur_rs   = 1'b1;
         end
         clcd_pkg::OP_INIT: begin
            last_idx = 3'd4;
            unique case (byte_ff)
               3'd0:    cur_byte = clcd_pkg::CMD_DISPLAY_ON;
               3'd1:    cur_byte = clcd_pkg::CMD_ENTRY_MODE;
               3'd2:    cur_byte = clcd_pkg::CMD_FUNC_SET;
               3'd3:    cur_byte = clcd_pkg::CMD_HOME;
               default: cur_byte = clcd_pkg::CMD_CLEAR;
            endcase
         end
         clcd_pkg::OP_CLEAR: begin
            last_idx = 3'd1;
            cur_byte = (byte_ff == 3'd0) ? clcd_pkg::CMD_HOME : clcd_pkg::CMD_CLEAR;
         end
         clcd_pkg::OP_GOTO: begin
            cur_byte = clcd_pkg::CMD_SET_DDRAM | {1'b0, acc_ff[6:0]};
         end
         clcd_pkg::OP_DIG4: begin
            last_idx = 3'd3;
            cur_rs   = 1'b1;
            cur_byte = clcd_pkg::ASCII_ZERO | {4'd0, dig_ff[byte_ff[1:0]]};
         end
         clcd_pkg::OP_DIG2: begin
            last_idx = 3'd1;
            cur_rs   = 1'b1;
            cur_byte = clcd_pkg::ASCII_ZERO | {4'd0, dig_ff[byte_ff[1:0]]};
         end
         default: begin
            cur_byte = '0;
         end
      endcase
      // The first two snapshots carry the high nibble, the rest the low nibble.
      cur_nib   = (snap_ff[2:1] == 2'd0) ? cur_byte[7:4] : cur_byte[3:0];
      last_byte = (byte_ff == last_idx);
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clcd_pkg::ST_IDLE;
         bus_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bus_ff   <= bus_in;
      end
   end

   // Working registers; only meaningful once a request is under way.
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      div_ff  <= div_in;
      dig_ff  <= dig_in;
      di_ff   <= di_in;
      byte_ff <= byte_in;
      snap_ff <= snap_in;
      pre_ff  <= pre_in;
   end

   // Next state and snapshot outputs.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      div_in     = div_ff;
      dig_in     = dig_ff;
      di_in      = di_ff;
      byte_in    = byte_ff;
      snap_in    = snap_ff;
      pre_in     = pre_ff;
      bus_in     = bus_ff;
      req_ready  = 1'b0;
      snap_valid = 1'b0;
      snap       = '0;

      unique case (state_ff)
         clcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_op != clcd_pkg::OP_UNUSED)) begin
               op_in   = clcd_pkg::opcode_type'(req_op);
               byte_in = '0;
               snap_in = '0;
               pre_in  = '0;
               dig_in  = '0;
               di_in   = '0;
               cnt_in  = req_row;
               div_in  = clcd_pkg::DIV_THOUSAND;
               acc_in  = req_value;
               unique case (clcd_pkg::opcode_type'(req_op))
                  clcd_pkg::OP_INIT: begin
                     state_in = clcd_pkg::ST_PRE;
                  end
                  clcd_pkg::OP_GOTO: begin
                     acc_in   = {7'd0, req_col};
                     state_in = clcd_pkg::ST_CALC;
                  end
                  clcd_pkg::OP_DIG4: begin
                     acc_in   = (req_value > clcd_pkg::DIG4_MAX) ? clcd_pkg::DIG4_MAX
                                                                 : req_value;
                     state_in = clcd_pkg::ST_CALC;
                  end
                  clcd_pkg::OP_DIG2: begin
                     acc_in   = (req_value > clcd_pkg::DIG2_MAX) ? clcd_pkg::DIG2_MAX
                                                                 : req_value;
                     div_in   = clcd_pkg::DIV_TEN;
                     state_in = clcd_pkg::ST_CALC;
                  end
                  default: begin
                     state_in = clcd_pkg::ST_EMIT;
                  end
               endcase
            end
         end

         clcd_pkg::ST_CALC: begin
            if (op_ff == clcd_pkg::OP_GOTO) begin
               // Row times width plus column, one addition per row.
               if (cnt_ff == 2'd0) begin
                  state_in = clcd_pkg::ST_EMIT;
               end else begin
                  acc_in = alu_rsp.res;
                  cnt_in = cnt_ff - 2'd1;
               end
            end else begin
               // Repeated subtraction counts the current decimal digit.
               if (!alu_rsp.borrow) begin
                  acc_in        = alu_rsp.res;
                  dig_in[di_ff] = dig_ff[di_ff] + 4'd1;
               end else if (div_ff == clcd_pkg::DIV_TEN) begin
                  dig_in[di_ff + 2'd1] = acc_ff[3:0];
                  state_in             = clcd_pkg::ST_EMIT;
               end else begin
                  div_in = div_ff + 2'd1;
                  di_in  = di_ff + 2'd1;
               end
            end
         end

         clcd_pkg::ST_PRE: begin
            // Power-up wait, then one strobe of the 4-bit select nibble.
            snap_valid      = 1'b1;
            snap.reg_select = 1'b0;
            snap.enable     = (pre_ff == 2'd1);
            snap.nibble     = (pre_ff == 2'd0) ? bus_ff : clcd_pkg::NIB_FOUR_BIT;
            snap.hold_units = (pre_ff == 2'd0) ? 7'(WaitUnits) : clcd_pkg::HOLD_MIN;
            snap.last       = 1'b0;
            if (advance) begin
               if (pre_ff == clcd_pkg::PRE_FINAL) begin
                  bus_in   = clcd_pkg::NIB_FOUR_BIT;
                  state_in = clcd_pkg::ST_EMIT;
               end else begin
                  pre_in = pre_ff + 2'd1;
               end
            end
         end

         clcd_pkg::ST_EMIT: begin
            // E is high on the second and fourth snapshot of each byte.
            snap_valid      = 1'b1;
            snap.reg_select = cur_rs;
            snap.enable     = snap_ff[0];
            snap.nibble     = cur_nib;
            snap.hold_units = clcd_pkg::HOLD_MIN;
            snap.last       = (snap_ff == clcd_pkg::SNAP_FINAL) && last_byte;
            if (advance) begin
               if (snap_ff == clcd_pkg::SNAP_FINAL) begin
                  bus_in  = cur_nib;
                  snap_in = '0;
                  if (last_byte) begin
                     state_in = clcd_pkg::ST_IDLE;
                  end else begin
                     byte_in = byte_ff + 3'd1;
                  end
               end else begin
                  snap_in = snap_ff + 3'd1;
               end
            end
         end

         default: begin
            state_in = clcd_pkg::ST_IDLE;
         end
      endcase
   end

   `CLCD_ASSERT_NEXT(a_unused_dropped,
      (state_ff == clcd_pkg::ST_IDLE) && req_valid && (req_op == clcd_pkg::OP_UNUSED),
      state_ff == clcd_pkg::ST_IDLE, "unused opcode started a request")
   `CLCD_ASSERT_NEXT(a_last_ends_request,
      snap_valid && advance && snap.last,
      state_ff == clcd_pkg::ST_IDLE, "request continued after its final snapshot")
   `CLCD_ASSERT_NEXT(a_bus_tracks_byte,
      (state_ff == clcd_pkg::ST_EMIT) && advance && (snap_ff == clcd_pkg::SNAP_FINAL),
      bus_ff == $past(snap.nibble), "bus level not updated after a byte")
   `CLCD_ASSERT_NOW(a_digit_decimal,
      (state_ff == clcd_pkg::ST_CALC) && (op_ff != clcd_pkg::OP_GOTO),
      dig_ff[di_ff] <= 4'd9, "decimal digit count exceeded nine")

endmodule
